// File: hdl/crc32_crc16_byte_engine_macros.svh
`ifndef CRC32_CRC16_BYTE_ENGINE_MACROS_SVH
`define CRC32_CRC16_BYTE_ENGINE_MACROS_SVH

// condition implies consequence in the same cycle
`define CRCBE_ASSERT_IMP(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("crcbe assertion failed");

// condition implies consequence in the next cycle
`define CRCBE_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("crcbe assertion failed");

`endif

// File: hdl/crcbe_pkg.sv
package crcbe_pkg;

   localparam logic [31:0] POLY32 = 32'hEDB8_8320;
   localparam logic [15:0] POLY16 = 16'h1021;
   localparam logic [31:0] ALL32  = 32'hFFFF_FFFF;
   localparam logic [15:0] ALL16  = 16'hFFFF;

   localparam logic [1:0] MODE_CRC32 = 2'd0;
   localparam logic [1:0] MODE_SEED  = 2'd1;
   localparam logic [1:0] MODE_CRC16 = 2'd2;

   localparam logic [7:0] CSR_MODE_IDX = 8'd0;
   localparam logic [7:0] CSR_SEED_IDX = 8'd1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] seed;
   } cfg_type;

   // reflected crc-32, one byte, lsb first
   function automatic logic [31:0] fold32(logic [31:0] r_in, logic [7:0] b);
      logic [31:0] r;
      r = r_in ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = (r >> 1) ^ (POLY32 & {32{r[0]}});
      end
      return r;
   endfunction

   // crc-16 ccitt, one byte, msb first
   function automatic logic [15:0] fold16(logic [15:0] r_in, logic [7:0] b);
      logic [15:0] r;
      r = r_in ^ {b, 8'd0};
      for (int i = 0; i < 8; i++) begin
         if (r[15]) begin
            r = (r << 1) ^ POLY16;
         end else begin
            r = r << 1;
         end
      end
      return r;
   endfunction

endpackage

// File: hdl/crcbe_csr.sv
module crcbe_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_index,
   input  logic [31:0]          csr_data,
   output crcbe_pkg::cfg_type   cfg
);
   import crcbe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE_IDX: cfg_in.mode = csr_data[1:0];
            CSR_SEED_IDX: cfg_in.seed = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= MODE_CRC32;
         cfg_ff.seed <= ALL32;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/crcbe_fold.sv
module crcbe_fold (
   input  crcbe_pkg::cfg_type   cfg,
   input  logic                 start,
   input  logic [31:0]          crc_reg,
   input  logic [7:0]           data_byte,
   output logic [31:0]          crc_next,
   output logic [31:0]          crc_result
);
   import crcbe_pkg::*;

   logic [31:0] base;

   always_comb begin
      base = crc_reg;
      if (start) begin
         case (cfg.mode)
            MODE_SEED:  base = cfg.seed;
            MODE_CRC16: base = {16'd0, ALL16};
            default:    base = ALL32;
         endcase
      end
      case (cfg.mode)
         MODE_CRC16: begin
            crc_next   = {16'd0, fold16(base[15:0], data_byte)};
            crc_result = crc_next;
         end
         MODE_SEED: begin
            crc_next   = fold32(base, data_byte);
            crc_result = crc_next;
         end
         default: begin
            crc_next   = fold32(base, data_byte);
            crc_result = ~crc_next;
         end
      endcase
   end

endmodule

// File: hdl/crc32_crc16_byte_engine.sv
// Byte-wide CRC engine: mode 0 gives reflected CRC-32 (init all ones, output
// inverted), mode 1 continues CRC-32 from the seed register without inversion,
// mode 2 gives CRC-16 CCITT-FALSE in the low 16 bits. Every request carries one
// byte and yields one response with the running CRC after that byte; tlast
// closes a message and the next byte reloads the start value. One request is
// taken per cycle: the byte is registered, folded through an eight-step XOR
// network and the result registered; throughput is one byte per clock while
// the response side keeps up. The user must write mode and seed through the
// csr port only while the engine is idle; the block does not enforce it.
`include "crc32_crc16_byte_engine_macros.svh"

module crc32_crc16_byte_engine (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // crc_value
   output logic         rsp_tlast,   // message_done
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import crcbe_pkg::*;

   cfg_type     cfg;
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_last_ff;
   logic [31:0] crc_ff;
   logic        inside_ff;
   logic [31:0] crc_in;
   logic [31:0] result_in;
   logic        out_ready;
   logic        in_ready;
   logic        advance;

   crcbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   crcbe_fold u_fold (
      .cfg        (cfg),
      .start      (!inside_ff),
      .crc_reg    (crc_ff),
      .data_byte  (in_byte_ff),
      .crc_next   (crc_in),
      .crc_result (result_in)
   );

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign in_ready   = !in_valid_ff || out_ready;
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = in_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= 32'd0;
         inside_ff    <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_ready) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            crc_ff    <= crc_in;
            inside_ff <= !in_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         rsp_data_ff <= result_in;
         rsp_last_ff <= in_last_ff;
      end
   end

   `CRCBE_ASSERT_IMP(a_open_matches_last, clock, reset,
      rsp_valid_ff, inside_ff == !rsp_last_ff)
   `CRCBE_ASSERT_IMP(a_result_from_reg, clock, reset,
      rsp_valid_ff, (rsp_data_ff == crc_ff) || (rsp_data_ff == ~crc_ff))
   `CRCBE_ASSERT_NEXT(a_held_byte_kept, clock, reset,
      in_valid_ff && !out_ready, in_valid_ff)

endmodule
